// File: sv/msx_pkg.sv
// Package for the MIPS subset execute unit: opcode and function codes,
// decoded request classes and the decoded request record shared by front end, queue and back end.
// No dependencies.
`default_nettype none
package msx_pkg;
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_JAL   = 6'b000011;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_BNE   = 6'b000101;
   localparam logic [5:0] OP_BLEZ  = 6'b000110;
   localparam logic [5:0] OP_BGTZ  = 6'b000111;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_SRL = 6'b000010;
   localparam logic [5:0] FN_JR  = 6'b001000;
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;

   localparam logic [31:0] HALT_WORD = 32'b00000000000000000000000000000000;
   localparam logic [4:0]  LINK_REG  = 5'd31;
   localparam int          PC_W      = 12;

   typedef enum logic [3:0] {
      K_PRE, K_HALT, K_SLL, K_SRL, K_ADD, K_SUB, K_JR, K_LW,
      K_SW, K_BEQ, K_BNE, K_BLEZ, K_BGTZ, K_J, K_JAL, K_BAD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [15:0] imm;
      logic [11:0] tgt;
      logic [11:0] paddr;
      logic [31:0] pdata;
   } dec_type;
endpackage
`default_nettype wire

// File: sv/msx_if.sv
// Request and response channel interfaces of the MIPS subset execute unit.
// No dependencies.
`default_nettype none
interface msx_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] instr_word;
   logic [11:0] preload_addr;
   logic [31:0] preload_data;
   modport source (output valid, req_type, instr_word, preload_addr, preload_data,
                   input ready);
   modport sink (input valid, req_type, instr_word, preload_addr, preload_data,
                 output ready);
endinterface

interface msx_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        next_pc;
   logic               reg_we;
   logic [4:0]         reg_sel;
   logic signed [31:0] reg_val;
   logic               mem_we;
   logic [11:0]        mem_addr;
   logic               halted;
   logic               status;
   modport source (output valid, next_pc, reg_we, reg_sel, reg_val, mem_we, mem_addr,
                   halted, status, input ready);
   modport sink (input valid, next_pc, reg_we, reg_sel, reg_val, mem_we, mem_addr,
                 halted, status, output ready);
endinterface
`default_nettype wire

// File: sv/msx_front.sv
// Front end: accepts requests and classifies each into a decoded record.
// Depends on msx_pkg.
`default_nettype none
module msx_front (
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_type,
   input  wire logic [31:0]     instr_word,
   input  wire logic [11:0]     preload_addr,
   input  wire logic [31:0]     preload_data,
   input  wire logic            clr_busy,
   output logic                 q_valid,
   input  wire logic            q_ready,
   output msx_pkg::dec_type     q_data
);
   logic [5:0] op;
   logic [5:0] fn;

   assign op        = instr_word[31:26];
   assign fn        = instr_word[5:0];
   assign req_ready = q_ready && !clr_busy;
   assign q_valid   = req_valid && !clr_busy;

   always_comb begin
      q_data.rs    = instr_word[25:21];
      q_data.rt    = instr_word[20:16];
      q_data.rd    = instr_word[15:11];
      q_data.sh    = instr_word[10:6];
      q_data.imm   = instr_word[15:0];
      q_data.tgt   = instr_word[11:0];
      q_data.paddr = preload_addr;
      q_data.pdata = preload_data;
      if (req_type) begin
         q_data.kind = msx_pkg::K_PRE;
      end else if (instr_word == msx_pkg::HALT_WORD) begin
         q_data.kind = msx_pkg::K_HALT;
      end else begin
         unique case (op)
            msx_pkg::OP_RTYPE: begin
               unique case (fn)
                  msx_pkg::FN_SLL: q_data.kind = msx_pkg::K_SLL;
                  msx_pkg::FN_SRL: q_data.kind = msx_pkg::K_SRL;
                  msx_pkg::FN_ADD: q_data.kind = msx_pkg::K_ADD;
                  msx_pkg::FN_SUB: q_data.kind = msx_pkg::K_SUB;
                  msx_pkg::FN_JR:  q_data.kind = msx_pkg::K_JR;
                  default:         q_data.kind = msx_pkg::K_BAD;
               endcase
            end
            msx_pkg::OP_LW:   q_data.kind = msx_pkg::K_LW;
            msx_pkg::OP_SW:   q_data.kind = msx_pkg::K_SW;
            msx_pkg::OP_BEQ:  q_data.kind = msx_pkg::K_BEQ;
            msx_pkg::OP_BNE:  q_data.kind = msx_pkg::K_BNE;
            msx_pkg::OP_BLEZ: q_data.kind = msx_pkg::K_BLEZ;
            msx_pkg::OP_BGTZ: q_data.kind = msx_pkg::K_BGTZ;
            msx_pkg::OP_J:    q_data.kind = msx_pkg::K_J;
            msx_pkg::OP_JAL:  q_data.kind = msx_pkg::K_JAL;
            default:          q_data.kind = msx_pkg::K_BAD;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: sv/msx_queue.sv
// Two-entry queue of decoded requests between front and back end.
// Depends on msx_pkg.
`default_nettype none
module msx_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire msx_pkg::dec_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output msx_pkg::dec_type      out_data
);
   msx_pkg::dec_type ent_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= in_data;
   end
endmodule
`default_nettype wire

// File: sv/msx_back.sv
// Back end: register file, data memory with clearing pass, program counter,
// execution sequencer and response register. Depends on msx_pkg.
`default_nettype none
module msx_back #(
   parameter int MEM_WORDS = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   output logic                    clr_busy,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire msx_pkg::dec_type   q_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [11:0]             next_pc,
   output logic                    reg_we,
   output logic [4:0]              reg_sel,
   output logic signed [31:0]      reg_val,
   output logic                    mem_we,
   output logic [11:0]             mem_addr,
   output logic                    halted,
   output logic                    status
);
   localparam int AW = $clog2(MEM_WORDS);
   localparam int XW = (AW > msx_pkg::PC_W) ? AW : msx_pkg::PC_W;
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EX   = 2'd1;
   localparam logic [1:0] S_MEM  = 2'd2;

   logic [1:0]       st_ff, st_in;
   logic [11:0]      pc_ff, pc_in;
   msx_pkg::dec_type cur_ff;
   logic [31:0]      a_ff, b_ff;
   logic [31:0]      rf_mem [32];
   logic [31:0]      rf_vld_ff;
   logic [31:0]      dmem [MEM_WORDS];
   logic [31:0]      mem_rd_ff;
   logic             clr_busy_ff;
   logic [AW-1:0]    clr_cnt_ff;

   logic [31:0] imm32, ea, rval;
   logic [11:0] npc, pc1, btgt;
   logic [AW-1:0] maddr;
   logic [XW-1:0] pa_x, ma_x;
   logic rwe, mwe, halt, bad, macc, out_free, fire;
   logic [4:0] rsel;

   assign clr_busy = clr_busy_ff;
   assign q_ready  = (st_ff == S_IDLE);
   assign out_free = !rsp_valid || rsp_ready;
   assign imm32    = {{16{cur_ff.imm[15]}}, cur_ff.imm};
   assign ea       = a_ff + imm32;
   assign pc1      = pc_ff + 12'd1;
   assign btgt     = pc1 + cur_ff.imm[11:0];
   assign pa_x     = XW'(cur_ff.paddr);

   always_comb begin
      npc = pc1; rwe = 1'b0; rsel = 5'd0; rval = '0; mwe = 1'b0;
      maddr = '0; macc = 1'b0; halt = 1'b0; bad = 1'b0;
      case (cur_ff.kind)
         msx_pkg::K_PRE: begin
            npc = pc_ff; mwe = 1'b1; macc = 1'b1; maddr = pa_x[AW-1:0];
         end
         msx_pkg::K_HALT: begin
            npc = pc_ff; halt = 1'b1;
         end
         msx_pkg::K_SLL: begin rwe = 1'b1; rsel = cur_ff.rd; rval = b_ff << cur_ff.sh; end
         msx_pkg::K_SRL: begin rwe = 1'b1; rsel = cur_ff.rd; rval = b_ff >> cur_ff.sh; end
         msx_pkg::K_ADD: begin rwe = 1'b1; rsel = cur_ff.rd; rval = a_ff + b_ff; end
         msx_pkg::K_SUB: begin rwe = 1'b1; rsel = cur_ff.rd; rval = a_ff - b_ff; end
         msx_pkg::K_JR:  npc = a_ff[11:0];
         msx_pkg::K_LW: begin
            macc = 1'b1; maddr = ea[AW-1:0]; rwe = 1'b1; rsel = cur_ff.rt; rval = mem_rd_ff;
         end
         msx_pkg::K_SW: begin
            macc = 1'b1; maddr = ea[AW-1:0]; mwe = 1'b1;
         end
         msx_pkg::K_BEQ:  if (a_ff == b_ff) npc = btgt;
         msx_pkg::K_BNE:  if (a_ff != b_ff) npc = btgt;
         msx_pkg::K_BLEZ: if (a_ff == '0 || a_ff[31]) npc = btgt;
         msx_pkg::K_BGTZ: if (a_ff != '0 && !a_ff[31]) npc = btgt;
         msx_pkg::K_J:    npc = cur_ff.tgt;
         msx_pkg::K_JAL: begin
            rwe = 1'b1; rsel = msx_pkg::LINK_REG; rval = 32'(pc1); npc = cur_ff.tgt;
         end
         default: bad = 1'b1;
      endcase
      if (rwe && rsel == 5'd0) begin
         rwe = 1'b0; rval = '0;
      end
      if (!rwe) rsel = 5'd0;
   end

   assign ma_x = XW'(maddr);
   assign fire = out_free && ((st_ff == S_EX && cur_ff.kind != msx_pkg::K_LW) ||
                              st_ff == S_MEM);

   always_comb begin
      st_in = st_ff;
      pc_in = pc_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid) st_in = S_EX;
         S_EX: begin
            if (cur_ff.kind == msx_pkg::K_LW) st_in = S_MEM;
            else if (fire) st_in = S_IDLE;
         end
         S_MEM: if (fire) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
      if (fire) pc_in = npc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         pc_ff       <= '0;
         rf_vld_ff   <= '0;
         rsp_valid   <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         st_ff <= st_in;
         pc_ff <= pc_in;
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MEM_WORDS - 1)) clr_busy_ff <= 1'b0;
         end
         if (fire && rwe) rf_vld_ff[rsel] <= 1'b1;
         if (fire) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid) begin
         cur_ff <= q_data;
         a_ff   <= rf_vld_ff[q_data.rs] ? rf_mem[q_data.rs] : '0;
         b_ff   <= rf_vld_ff[q_data.rt] ? rf_mem[q_data.rt] : '0;
      end
      if (fire && rwe) rf_mem[rsel] <= rval;
      if (fire) begin
         next_pc  <= npc;
         reg_we   <= rwe;
         reg_sel  <= rsel;
         reg_val  <= rval;
         mem_we   <= mwe;
         mem_addr <= macc ? ma_x[11:0] : 12'd0;
         halted   <= halt;
         status   <= bad;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_cnt_ff] <= '0;
      end else if (fire && mwe) begin
         dmem[maddr] <= (cur_ff.kind == msx_pkg::K_PRE) ? cur_ff.pdata : b_ff;
      end
      if (st_ff == S_EX && cur_ff.kind == msx_pkg::K_LW) mem_rd_ff <= dmem[maddr];
   end
endmodule
`default_nettype wire

// File: sv/mips_subset_execute_unit_core.sv
// The back end reads the register file as it takes a request, then executes it
// and loads the response register; lw adds a state for the data memory read.
// Requests queue two deep behind the back end, so a new request is accepted
// while a response waits. After reset a clearing pass zeroes the data memory,
// during which no request is taken. MEM_WORDS must be a power of two; the block
// does not enforce it. Depends on msx_pkg, msx_if, front, queue, back.
`default_nettype none
module mips_subset_execute_unit_core #(
   parameter int MEM_WORDS = 4096
) (
   input wire logic   clock,
   input wire logic   reset,
   msx_req_if.sink    req_ch,
   msx_rsp_if.source  rsp_ch
);
   logic             clr_busy;
   logic             fq_valid, fq_ready, qb_valid, qb_ready;
   msx_pkg::dec_type fq_data, qb_data;

   msx_front u_front (
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_type(req_ch.req_type),
      .instr_word(req_ch.instr_word), .preload_addr(req_ch.preload_addr),
      .preload_data(req_ch.preload_data), .clr_busy(clr_busy),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
   );

   msx_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(fq_valid), .in_ready(fq_ready),
      .in_data(fq_data), .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   msx_back #(.MEM_WORDS(MEM_WORDS)) u_back (
      .clock(clock), .reset(reset), .clr_busy(clr_busy),
      .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .next_pc(rsp_ch.next_pc),
      .reg_we(rsp_ch.reg_we), .reg_sel(rsp_ch.reg_sel), .reg_val(rsp_ch.reg_val),
      .mem_we(rsp_ch.mem_we), .mem_addr(rsp_ch.mem_addr), .halted(rsp_ch.halted),
      .status(rsp_ch.status)
   );
endmodule
`default_nettype wire

// File: sv/msx_checker.sv
// Port-level checker for the MIPS subset execute unit and its bind.
// Depends on mips_subset_execute_unit_core.
`default_nettype none
module msx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        reg_we,
   input wire logic [4:0]  reg_sel,
   input wire logic [31:0] reg_val,
   input wire logic        mem_we,
   input wire logic        halted,
   input wire logic        status
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(reg_val) && $stable(reg_sel))
      else $error("response dropped or changed while stalled");
   a_noz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reg_we |-> reg_sel != 5'd0)
      else $error("write to register zero reported");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reg_we |-> reg_sel == 5'd0 && reg_val == 32'd0)
      else $error("register fields not cleared");
   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halted |-> !reg_we && !mem_we && !status)
      else $error("halt with side effects");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");
endmodule

bind mips_subset_execute_unit_core msx_checker u_msx_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .reg_we(rsp_ch.reg_we), .reg_sel(rsp_ch.reg_sel), .reg_val(rsp_ch.reg_val),
   .mem_we(rsp_ch.mem_we), .halted(rsp_ch.halted), .status(rsp_ch.status)
);
`default_nettype wire
